@@ sv/fhp_pkg.sv @@
// Package for the ethernet ipv4 tcp/udp flow header parser.
// Holds the frame layout constants, protocol codes and stream bit positions.
// No dependencies; used by the parser top level and its checker.
package fhp_pkg;

  // default width of the frame byte position counter
  localparam int unsigned OFFSET_BITS_DEF = 16;

  // frame layout
  localparam logic [7:0]  ETH_HDR_LEN    = 8'd14;
  localparam logic [5:0]  MIN_HDR_LEN    = 6'd20;
  localparam logic [3:0]  MIN_HDR_WORDS  = 4'd5;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;

  // byte positions inside the frame
  localparam int unsigned POS_ETYPE_HI = 12;
  localparam int unsigned POS_ETYPE_LO = 13;
  localparam int unsigned POS_IHL      = 14;
  localparam int unsigned POS_TOTAL_HI = 16;
  localparam int unsigned POS_TOTAL_LO = 17;
  localparam int unsigned POS_PROTO    = 23;
  localparam int unsigned POS_SRC_LO   = 26;
  localparam int unsigned POS_SRC_HI   = 29;
  localparam int unsigned POS_DST_LO   = 30;
  localparam int unsigned POS_DST_HI   = 33;
  localparam int unsigned TCP_OFF_POS  = 12;

  // ip protocol numbers
  localparam logic [7:0] IP_PROTO_TCP = 8'd6;
  localparam logic [7:0] IP_PROTO_UDP = 8'd17;

  // request method prefixes
  localparam logic [23:0] HTTP_GET  = 24'h474554;
  localparam logic [31:0] HTTP_POST = 32'h504F5354;

  // result stream packing
  localparam int unsigned OUT_DATA_W = 112;
  localparam int unsigned OUT_USER_W = 3;
  localparam int unsigned USER_VALID = 0;
  localparam int unsigned USER_UDP   = 1;
  localparam int unsigned USER_HTTP  = 2;

endpackage

@@ sv/ipv4_tcp_udp_flow_header_parser_unit.sv @@
// The flow record is registered and shows on the master side in the cycle after the last frame byte is accepted.
// The input takes one frame byte per cycle while not stalled; the next frame may start right after a last byte.
// The input stalls only while a finished record waits on the master side.
// Reset (rst_ni low, asynchronous) clears the frame state and drops the record valid.
// Depends on fhp_pkg for frame layout and protocol constants.
module ipv4_tcp_udp_flow_header_parser_unit #(
  parameter int unsigned OFFSET_BITS = fhp_pkg::OFFSET_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // frame byte stream
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  input  logic [7:0]                      s_axis_tdata_i,  // [7:0] frame_byte
  input  logic                            s_axis_tlast_i,  // last_byte
  // flow record stream
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [31:0] source_address, [63:32] dest_address, [79:64] source_port,
  // [95:80] dest_port, [111:96] payload_len
  output logic [fhp_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // [0] flow_valid, [1] protocol_kind, [2] http_request
  output logic [fhp_pkg::OUT_USER_W-1:0]  m_axis_tuser_o
);

  localparam int unsigned PW = OFFSET_BITS;
  localparam int unsigned CW = (PW + 1 > 17) ? PW + 1 : 17;
  localparam logic [PW-1:0] POS_MAX = {PW{1'b1}};

  // frame state
  logic [PW-1:0] pos_q;
  logic [15:0]   ether_q, ether_d;
  logic [3:0]    ip_words_q, ip_words_d;
  logic [15:0]   ip_total_q, ip_total_d;
  logic [7:0]    proto_q, proto_d;
  logic [31:0]   src_addr_q, src_addr_d;
  logic [31:0]   dst_addr_q, dst_addr_d;
  logic [15:0]   src_port_q, src_port_d;
  logic [15:0]   dst_port_q, dst_port_d;
  logic [3:0]    tcp_words_q, tcp_words_d;
  logic [31:0]   head_q, head_d;

  // result register
  logic                           out_valid_q;
  logic [fhp_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;
  logic [fhp_pkg::OUT_USER_W-1:0] out_user_q, out_user_d;

  logic in_acc;
  logic [7:0] b;

  assign b               = s_axis_tdata_i;
  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // transport and payload start positions from the stored header lengths
  logic          hdr_ok, pay_ok;
  logic [7:0]    t_pos, p_pos;
  logic [PW-1:0] t_w, p_w, p_diff;

  assign hdr_ok = (pos_q > PW'(fhp_pkg::POS_IHL)) && (ip_words_q >= fhp_pkg::MIN_HDR_WORDS);
  assign t_pos  = fhp_pkg::ETH_HDR_LEN + {2'b00, ip_words_q, 2'b00};
  assign p_pos  = t_pos + {2'b00, tcp_words_q, 2'b00};
  assign t_w    = PW'(t_pos);
  assign p_w    = PW'(p_pos);
  assign p_diff = pos_q - p_w;
  assign pay_ok = hdr_ok && (pos_q > t_w + PW'(fhp_pkg::TCP_OFF_POS)) &&
                  (tcp_words_q >= fhp_pkg::MIN_HDR_WORDS);

  // capture the current byte into the header fields
  always_comb begin
    ether_d     = ether_q;
    ip_words_d  = ip_words_q;
    ip_total_d  = ip_total_q;
    proto_d     = proto_q;
    src_addr_d  = src_addr_q;
    dst_addr_d  = dst_addr_q;
    src_port_d  = src_port_q;
    dst_port_d  = dst_port_q;
    tcp_words_d = tcp_words_q;
    head_d      = head_q;
    if (pos_q == PW'(fhp_pkg::POS_ETYPE_HI) || pos_q == PW'(fhp_pkg::POS_ETYPE_LO)) begin
      ether_d = {ether_q[7:0], b};
    end
    if (pos_q == PW'(fhp_pkg::POS_IHL)) begin
      ip_words_d = b[3:0];
    end
    if (pos_q == PW'(fhp_pkg::POS_TOTAL_HI) || pos_q == PW'(fhp_pkg::POS_TOTAL_LO)) begin
      ip_total_d = {ip_total_q[7:0], b};
    end
    if (pos_q == PW'(fhp_pkg::POS_PROTO)) begin
      proto_d = b;
    end
    if (pos_q >= PW'(fhp_pkg::POS_SRC_LO) && pos_q <= PW'(fhp_pkg::POS_SRC_HI)) begin
      src_addr_d = {src_addr_q[23:0], b};
    end
    if (pos_q >= PW'(fhp_pkg::POS_DST_LO) && pos_q <= PW'(fhp_pkg::POS_DST_HI)) begin
      dst_addr_d = {dst_addr_q[23:0], b};
    end
    if (hdr_ok) begin
      if (pos_q == t_w || pos_q == t_w + PW'(1)) begin
        src_port_d = {src_port_q[7:0], b};
      end
      if (pos_q == t_w + PW'(2) || pos_q == t_w + PW'(3)) begin
        dst_port_d = {dst_port_q[7:0], b};
      end
      if (pos_q == t_w + PW'(fhp_pkg::TCP_OFF_POS)) begin
        tcp_words_d = b[7:4];
      end
    end
    if (pay_ok && pos_q >= p_w && p_diff < PW'(4)) begin
      case (p_diff[1:0])
        2'd0:    head_d[31:24] = b;
        2'd1:    head_d[23:16] = b;
        2'd2:    head_d[15:8]  = b;
        default: head_d[7:0]   = b;
      endcase
    end
  end

  // length checks and record build on the captured fields
  logic [5:0]    ihl, thl;
  logic [7:0]    te;
  logic [PW:0]   caplen;
  logic          base_ok, tcp_ok, udp_ok, rec_valid, http;
  logic [15:0]   tcp_plen, udp_plen;
  logic [CW-1:0] need;

  always_comb begin
    ihl      = {ip_words_d, 2'b00};
    thl      = {tcp_words_d, 2'b00};
    te       = fhp_pkg::ETH_HDR_LEN + {2'b00, ihl};
    caplen   = {1'b0, pos_q} + (PW+1)'(1);
    base_ok  = (ether_d == fhp_pkg::ETHERTYPE_IPV4) && (ihl >= fhp_pkg::MIN_HDR_LEN) &&
               (caplen >= (PW+1)'(te) + (PW+1)'(4));
    tcp_ok   = (proto_d == fhp_pkg::IP_PROTO_TCP) &&
               (caplen >= (PW+1)'(te) + (PW+1)'(fhp_pkg::TCP_OFF_POS + 1)) &&
               (thl >= fhp_pkg::MIN_HDR_LEN) &&
               (ip_total_d >= 16'(ihl) + 16'(thl));
    tcp_plen = ip_total_d - 16'(ihl) - 16'(thl);
    udp_ok   = (proto_d == fhp_pkg::IP_PROTO_UDP) &&
               (ip_total_d >= 16'(ihl) + fhp_pkg::UDP_HDR_LEN);
    udp_plen = ip_total_d - 16'(ihl) - fhp_pkg::UDP_HDR_LEN;
    need     = CW'(te) + CW'(thl) + CW'(tcp_plen);
    http     = (tcp_plen != 16'd0) && (CW'(caplen) >= need) &&
               (((tcp_plen >= 16'd3) && (head_d[31:8] == fhp_pkg::HTTP_GET)) ||
                ((tcp_plen >= 16'd4) && (head_d == fhp_pkg::HTTP_POST)));
    rec_valid = base_ok && (tcp_ok || udp_ok);

    out_data_d = '0;
    out_user_d = '0;
    if (rec_valid) begin
      out_data_d = {(tcp_ok ? tcp_plen : udp_plen), dst_port_d, src_port_d,
                    dst_addr_d, src_addr_d};
      out_user_d[fhp_pkg::USER_VALID] = 1'b1;
      out_user_d[fhp_pkg::USER_UDP]   = !tcp_ok;
      out_user_d[fhp_pkg::USER_HTTP]  = tcp_ok && http;
    end
  end

  // frame state registers, cleared after each last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      ether_q     <= '0;
      ip_words_q  <= '0;
      ip_total_q  <= '0;
      proto_q     <= '0;
      src_addr_q  <= '0;
      dst_addr_q  <= '0;
      src_port_q  <= '0;
      dst_port_q  <= '0;
      tcp_words_q <= '0;
      head_q      <= '0;
    end else if (in_acc) begin
      if (s_axis_tlast_i) begin
        pos_q       <= '0;
        ether_q     <= '0;
        ip_words_q  <= '0;
        ip_total_q  <= '0;
        proto_q     <= '0;
        src_addr_q  <= '0;
        dst_addr_q  <= '0;
        src_port_q  <= '0;
        dst_port_q  <= '0;
        tcp_words_q <= '0;
        head_q      <= '0;
      end else begin
        pos_q       <= (pos_q == POS_MAX) ? pos_q : pos_q + PW'(1);
        ether_q     <= ether_d;
        ip_words_q  <= ip_words_d;
        ip_total_q  <= ip_total_d;
        proto_q     <= proto_d;
        src_addr_q  <= src_addr_d;
        dst_addr_q  <= dst_addr_d;
        src_port_q  <= src_port_d;
        dst_port_q  <= dst_port_d;
        tcp_words_q <= tcp_words_d;
        head_q      <= head_d;
      end
    end
  end

  // record valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_acc && s_axis_tlast_i) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // record payload
  always_ff @(posedge clk_i) begin
    if (in_acc && s_axis_tlast_i) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

endmodule

@@ sv/fhp_checker.sv @@
// Port-level checker for the flow header parser, bound to the top level.
// Depends on fhp_pkg for the record bit positions.
module fhp_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic                            s_axis_tlast_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [fhp_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  input logic [fhp_pkg::OUT_USER_W-1:0]  m_axis_tuser_o
);

  // input side never stalls while no record is pending
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty result register");

  // a stalled record holds its contents
  a_hold_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("stalled record changed");

  // a rejected frame gives an all-zero record
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tuser_o[fhp_pkg::USER_VALID] |->
      m_axis_tdata_o == '0 && m_axis_tuser_o == '0)
    else $error("rejected frame record not cleared");

  // request flag only on a valid tcp record
  a_http_tcp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[fhp_pkg::USER_HTTP] |->
      m_axis_tuser_o[fhp_pkg::USER_VALID] && !m_axis_tuser_o[fhp_pkg::USER_UDP])
    else $error("request flag on non-tcp record");

  // each new record follows a last-byte transaction
  a_record_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!m_axis_tvalid_o || m_axis_tready_i) ##1 m_axis_tvalid_o |->
      $past(s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i))
    else $error("record without a last byte");

endmodule

bind ipv4_tcp_udp_flow_header_parser_unit fhp_checker u_fhp_checker (.*);
